/* hdl/dcm_est_pkg.sv */
package dcm_est_pkg;

   localparam int FRAC_BITS  = 13;
   localparam int ASIN_DEPTH = 512;
   localparam int ASIN_IDX_W = $clog2(ASIN_DEPTH);

   // Register file layout of the shared datapath
   localparam int RF_DEPTH = 28;
   localparam int RF_IDX_W = 5;
   localparam int RM = 0;    // cosine matrix, row-major
   localparam int RI = 9;    // integral term
   localparam int RG = 12;   // gyro rate, later the new bottom row
   localparam int RA = 15;   // accel, later the rotated top row
   localparam int RR = 18;   // drift error, later the rotated middle row
   localparam int RD = 21;   // angle increments
   localparam int RT = 24;   // orthogonality error
   localparam int RS = 25;   // row weights

   // Operand source codes beyond the register file
   localparam int SRC_W      = 6;
   localparam int SRC_GAIN   = 32;
   localparam int SRC_SCALE  = 33;
   localparam int SRC_DT     = 34;
   localparam int SRC_CG     = 35;
   localparam int SRC_ONE    = 36;
   localparam int SRC_SH8    = 37;
   localparam int SRC_HALF   = 38;
   localparam int SRC_NHALF  = 39;
   localparam int SRC_ZERO   = 40;
   localparam int SRC_THREE  = 41;

   localparam int STEP_W    = 7;
   localparam int LAST_STEP = 72;

   // Configuration register indexes
   localparam logic [2:0] CSR_BIAS_X = 3'd0;
   localparam logic [2:0] CSR_BIAS_Y = 3'd1;
   localparam logic [2:0] CSR_BIAS_Z = 3'd2;
   localparam logic [2:0] CSR_SCALE  = 3'd3;
   localparam logic [2:0] CSR_GAIN   = 3'd4;
   localparam logic [2:0] CSR_DT     = 3'd5;
   localparam logic [2:0] CSR_CG     = 3'd6;
   localparam logic [2:0] CSR_IVAL   = 3'd7;

   typedef struct packed {
      logic signed [15:0] gyro_x;
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_z;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] pitch;
      logic signed [15:0] roll;
   } rsp_word_type;

   // One micro-op: dst = add +/- (a * b [>>> FRAC_BITS])
   typedef struct packed {
      logic [RF_IDX_W-1:0] dst;
      logic [SRC_W-1:0]    src_a;
      logic [SRC_W-1:0]    src_b;
      logic [SRC_W-1:0]    src_add;
      logic                sub;
      logic                shift;
   } uop_type;

   function automatic uop_type mk(int d, int a, int b, int ad, bit s, bit sh);
      uop_type u;
      u.dst     = RF_IDX_W'(d);
      u.src_a   = SRC_W'(a);
      u.src_b   = SRC_W'(b);
      u.src_add = SRC_W'(ad);
      u.sub     = s;
      u.shift   = sh;
      return u;
   endfunction

   // Micro-program for one sample
   function automatic uop_type uop(logic [STEP_W-1:0] step);
      int s;
      int i;
      int m;
      int b;
      uop_type u;
      s = int'(step);
      u = mk(RT, SRC_ZERO, SRC_ZERO, RT, 1'b0, 1'b0);
      case (step) inside
         [0:2]: begin
            i = s;
            u = mk(RG + i, RG + i, SRC_GAIN, SRC_ZERO, 1'b0, 1'b1);
         end
         [3:5]: begin
            i = s - 3;
            u = mk(RA + i, RA + i, SRC_SCALE, SRC_ZERO, 1'b0, 1'b0);
         end
         6:  u = mk(RR + 0, RM + 7, RA + 2, SRC_ZERO, 1'b0, 1'b1);
         7:  u = mk(RR + 0, RM + 8, RA + 1, RR + 0, 1'b1, 1'b1);
         8:  u = mk(RR + 1, RM + 8, RA + 0, SRC_ZERO, 1'b0, 1'b1);
         9:  u = mk(RR + 1, RM + 6, RA + 2, RR + 1, 1'b1, 1'b1);
         10: u = mk(RR + 2, RM + 6, RA + 1, SRC_ZERO, 1'b0, 1'b1);
         11: u = mk(RR + 2, RM + 7, RA + 0, RR + 2, 1'b1, 1'b1);
         [12:14]: begin
            i = s - 12;
            u = mk(RI + i, RR + i, SRC_SH8, RI + i, 1'b0, 1'b1);
         end
         [15:17]: begin
            i = s - 15;
            u = mk(RG + i, RR + i, SRC_CG, RG + i, 1'b1, 1'b1);
         end
         [18:20]: begin
            i = s - 18;
            u = mk(RG + i, RI + i, SRC_ONE, RG + i, 1'b1, 1'b1);
         end
         [21:23]: begin
            i = s - 21;
            u = mk(RD + i, RG + i, SRC_DT, SRC_ZERO, 1'b0, 1'b1);
         end
         [24:35]: begin
            i = (s < 30) ? s - 24 : s - 30;
            m = (s < 30) ? RM : RM + 3;
            b = (s < 30) ? RA : RR;
            case (i)
               0: u = mk(b + 0, RD + 2, m + 1, m + 0, 1'b0, 1'b1);
               1: u = mk(b + 0, RD + 1, m + 2, b + 0, 1'b1, 1'b1);
               2: u = mk(b + 1, RD + 2, m + 0, m + 1, 1'b1, 1'b1);
               3: u = mk(b + 1, RD + 0, m + 2, b + 1, 1'b0, 1'b1);
               4: u = mk(b + 2, RD + 1, m + 0, m + 2, 1'b0, 1'b1);
               default: u = mk(b + 2, RD + 0, m + 1, b + 2, 1'b1, 1'b1);
            endcase
         end
         36: u = mk(RT, RA + 0, RR + 0, SRC_ZERO, 1'b0, 1'b1);
         37: u = mk(RT, RA + 1, RR + 1, RT, 1'b0, 1'b1);
         38: u = mk(RT, RA + 2, RR + 2, RT, 1'b0, 1'b1);
         39: u = mk(RT, RT, SRC_HALF, SRC_ZERO, 1'b0, 1'b1);
         [40:42]: begin
            i = s - 40;
            u = mk(RM + i, RT, RR + i, RA + i, 1'b1, 1'b1);
         end
         [43:45]: begin
            i = s - 43;
            u = mk(RM + 3 + i, RT, RA + i, RR + i, 1'b1, 1'b1);
         end
         46: u = mk(RG + 0, RM + 1, RM + 5, SRC_ZERO, 1'b0, 1'b1);
         47: u = mk(RG + 0, RM + 2, RM + 4, RG + 0, 1'b1, 1'b1);
         48: u = mk(RG + 1, RM + 2, RM + 3, SRC_ZERO, 1'b0, 1'b1);
         49: u = mk(RG + 1, RM + 0, RM + 5, RG + 1, 1'b1, 1'b1);
         50: u = mk(RG + 2, RM + 0, RM + 4, SRC_ZERO, 1'b0, 1'b1);
         51: u = mk(RG + 2, RM + 1, RM + 3, RG + 2, 1'b1, 1'b1);
         [52:60]: begin
            b = (s < 55) ? 0 : ((s < 58) ? 1 : 2);
            i = s - 52 - 3 * b;
            m = (b == 0) ? RM : ((b == 1) ? RM + 3 : RG);
            u = mk(RS + b, m + i, m + i, (i == 0) ? SRC_ZERO : RS + b, 1'b0, 1'b1);
         end
         [61:63]: begin
            i = s - 61;
            u = mk(RS + i, RS + i, SRC_NHALF, SRC_THREE, 1'b0, 1'b1);
         end
         [64:72]: begin
            b = (s < 67) ? 0 : ((s < 70) ? 1 : 2);
            i = s - 64 - 3 * b;
            m = (b == 2) ? RG : RM + 3 * b;
            u = mk(RM + 3 * b + i, m + i, RS + b, SRC_ZERO, 1'b0, 1'b1);
         end
         default: u = mk(RT, RT, SRC_ZERO, RT, 1'b0, 1'b0);
      endcase
      return u;
   endfunction

   // Sine of a non-negative Q30 angle, Q30 result (series, elaboration only)
   function automatic logic [63:0] sin_q30(logic [63:0] x);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int k = 1; k <= 12; k++) begin
         term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      return (sum < 0) ? 64'd0 : 64'(sum);
   endfunction

   // Build the asin table: entry i is asin(i / ASIN_DEPTH) in fixed point
   function automatic logic [ASIN_DEPTH*16-1:0] build_asin();
      logic [ASIN_DEPTH*16-1:0] t;
      logic [63:0]              top;
      logic [63:0]              target;
      logic [63:0]              lo;
      logic [63:0]              hi;
      logic [63:0]              mid;
      t   = '0;
      top = (64'd1686629713 >> (30 - FRAC_BITS)) + 64'd1;
      for (int i = 0; i < ASIN_DEPTH; i++) begin
         target = (64'(i) << 30) / ASIN_DEPTH;
         lo = 64'd0;
         hi = top;
         for (int n = 0; n < 24; n++) begin
            if (lo < hi) begin
               mid = (lo + hi) >> 1;
               if (sin_q30(((64'd2 * mid) + 64'd1) << (29 - FRAC_BITS)) >= target) begin
                  hi = mid;
               end else begin
                  lo = mid + 64'd1;
               end
            end
         end
         t[i*16 +: 16] = lo[15:0];
      end
      return t;
   endfunction

   localparam logic [ASIN_DEPTH*16-1:0] ASIN_ROM = build_asin();

endpackage

/* hdl/dcm_attitude_estimator_unit.sv */
// A sample is taken in ST_IDLE, then ST_RUN works through 73 shared multiply-add steps.
// A result, when due, follows via the two asin table reads in ST_ASIN_P and ST_ASIN_R,
// then the output word in ST_EMIT, which waits for a free slot. A new sample is taken only
// in ST_IDLE; a single signed 17x17 multiplier with one adder serves every step.
// Reset (synchronous): matrix to identity, integral to zero, countdown to 10, registers
// to their defaults, no result pending.
module dcm_attitude_estimator_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  dcm_est_pkg::req_word_type  req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output dcm_est_pkg::rsp_word_type  rsp_data,
   input  logic                       csr_we,
   input  logic [2:0]                 csr_index,
   input  logic [15:0]                csr_wdata
);
   import dcm_est_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_RUN    = 5'b00010,
      ST_ASIN_P = 5'b00100,
      ST_ASIN_R = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   step_ff;
   logic [15:0]         rf_ff [RF_DEPTH];
   logic [7:0]          count_ff;
   logic                rsp_valid_ff;
   rsp_word_type        rsp_data_ff;
   logic [15:0]         pitch_ff;
   logic [15:0]         rom_q_ff;

   logic signed [11:0]  bias_x_ff, bias_y_ff, bias_z_ff;
   logic [7:0]          scale_ff;
   logic [15:0]         gain_ff;
   logic [12:0]         dt_ff;
   logic [14:0]         cg_ff;
   logic [7:0]          ival_ff;

   uop_type             u;
   logic signed [16:0]  op_a, op_b;
   logic [15:0]         op_add;
   logic signed [33:0]  prod;
   logic signed [33:0]  prod_sh;
   logic [15:0]         term;
   logic [15:0]         result;
   logic [7:0]          count_dec;
   logic [ASIN_IDX_W-1:0] rom_addr;
   logic [15:0]         rom_x;
   logic [15:0]         roll_val;

   // Operand fetch from register file or constants
   function automatic logic signed [16:0] fetch(logic [SRC_W-1:0] c,
                                                 logic [15:0] rv,
                                                 logic [15:0] gain,
                                                 logic [7:0] scale,
                                                 logic [12:0] dt,
                                                 logic [14:0] cg);
      logic signed [16:0] v;
      v = '0;
      if (c < SRC_W'(RF_DEPTH)) begin
         v = 17'(signed'(rv));
      end else begin
         case (int'(c))
            SRC_GAIN:  v = signed'({1'b0, gain});
            SRC_SCALE: v = signed'({9'b0, scale});
            SRC_DT:    v = signed'({4'b0, dt});
            SRC_CG:    v = signed'({2'b0, cg});
            SRC_ONE:   v = 17'sd1 <<< FRAC_BITS;
            SRC_SH8:   v = 17'sd1 <<< (FRAC_BITS - 8);
            SRC_HALF:  v = 17'sd1 <<< (FRAC_BITS - 1);
            SRC_NHALF: v = -(17'sd1 <<< (FRAC_BITS - 1));
            SRC_THREE: v = 17'(3 <<< (FRAC_BITS - 1));
            default:   v = '0;
         endcase
      end
      return v;
   endfunction

   // Table index of the magnitude's fraction bits
   function automatic logic [ASIN_IDX_W-1:0] asin_idx(logic [15:0] x);
      logic [15:0]                      mag;
      logic [FRAC_BITS+ASIN_IDX_W-1:0]  wide;
      mag  = x[15] ? 16'(-x) : x;
      wide = {mag[FRAC_BITS-1:0], {ASIN_IDX_W{1'b0}}};
      return wide[FRAC_BITS+ASIN_IDX_W-1:FRAC_BITS];
   endfunction

   function automatic logic [15:0] asin_sign(logic [15:0] x, logic [15:0] v);
      return x[15] ? 16'(-v) : v;
   endfunction

   // Shared multiply-add unit
   always_comb begin
      u       = uop(step_ff);
      op_a    = fetch(u.src_a, rf_ff[u.src_a[RF_IDX_W-1:0]], gain_ff, scale_ff,
                      dt_ff, cg_ff);
      op_b    = fetch(u.src_b, rf_ff[u.src_b[RF_IDX_W-1:0]], gain_ff, scale_ff,
                      dt_ff, cg_ff);
      op_add  = 16'(fetch(u.src_add, rf_ff[u.src_add[RF_IDX_W-1:0]], gain_ff,
                          scale_ff, dt_ff, cg_ff));
      prod    = op_a * op_b;
      prod_sh = u.shift ? (prod >>> FRAC_BITS) : prod;
      term    = prod_sh[15:0];
      result  = u.sub ? (op_add - term) : (op_add + term);
   end

   // Asin table port: pitch first, then roll
   assign rom_x     = (state_ff == ST_ASIN_P) ? rf_ff[RM + 6] : rf_ff[RM + 7];
   assign rom_addr  = asin_idx(rom_x);
   assign roll_val  = asin_sign(rf_ff[RM + 7], rom_q_ff);
   assign count_dec = count_ff - 8'd1;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (step_ff == STEP_W'(LAST_STEP)) begin
               state_in = (count_dec == 8'd0) ? ST_ASIN_P : ST_IDLE;
            end
         end
         ST_ASIN_P: state_in = ST_ASIN_R;
         ST_ASIN_R: state_in = ST_EMIT;
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= 8'd10;
         rsp_valid_ff <= 1'b0;
         bias_x_ff    <= 12'sd11;
         bias_y_ff    <= 12'sd1;
         bias_z_ff    <= 12'sd4;
         scale_ff     <= 8'd8;
         gain_ff      <= 16'd10580;
         dt_ff        <= 13'd82;
         cg_ff        <= 15'd9011;
         ival_ff      <= 8'd10;
         for (int i = 0; i < RF_DEPTH; i++) begin
            rf_ff[i] <= (i == RM || i == RM + 4 || i == RM + 8) ? 16'(1 << FRAC_BITS) : '0;
         end
      end else begin
         state_ff <= state_in;

         // Write configuration
         if (csr_we) begin
            unique case (csr_index)
               CSR_BIAS_X: bias_x_ff <= signed'(csr_wdata[11:0]);
               CSR_BIAS_Y: bias_y_ff <= signed'(csr_wdata[11:0]);
               CSR_BIAS_Z: bias_z_ff <= signed'(csr_wdata[11:0]);
               CSR_SCALE:  scale_ff  <= csr_wdata[7:0];
               CSR_GAIN:   gain_ff   <= csr_wdata;
               CSR_DT:     dt_ff     <= csr_wdata[12:0];
               CSR_CG:     cg_ff     <= csr_wdata[14:0];
               CSR_IVAL:   ival_ff   <= csr_wdata[7:0];
               default: ;
            endcase
         end

         // Load the sample: raw gyro, shifted and de-biased accel
         if (state_ff == ST_IDLE && req_valid) begin
            step_ff        <= '0;
            rf_ff[RG + 0]  <= req_data.gyro_x;
            rf_ff[RG + 1]  <= req_data.gyro_y;
            rf_ff[RG + 2]  <= req_data.gyro_z;
            rf_ff[RA + 0]  <= 16'(13'(signed'(req_data.accel_x[15:4])) - 13'(bias_x_ff));
            rf_ff[RA + 1]  <= 16'(13'(signed'(req_data.accel_y[15:4])) - 13'(bias_y_ff));
            rf_ff[RA + 2]  <= 16'(13'(signed'(req_data.accel_z[15:4])) - 13'(bias_z_ff));
         end

         // Advance one micro-op
         if (state_ff == ST_RUN) begin
            rf_ff[u.dst] <= result;
            step_ff      <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(LAST_STEP)) begin
               count_ff <= (count_dec == 8'd0) ? ((ival_ff == 8'd0) ? 8'd1 : ival_ff)
                                               : count_dec;
            end
         end

         // Load a new result when the slot frees, else drop the one taken
         if (state_ff == ST_EMIT && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Table reads and result word
   always_ff @(posedge clock) begin
      rom_q_ff <= ASIN_ROM[rom_addr * 16 +: 16];
      if (state_ff == ST_ASIN_R) begin
         pitch_ff <= asin_sign(rf_ff[RM + 6], rom_q_ff);
      end
      if (state_ff == ST_EMIT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_data_ff.pitch <= pitch_ff;
         rsp_data_ff.roll  <= roll_val;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* tb/dcm_attitude_estimator_unit_checker.sv */
`timescale 1ns / 1ps

module dcm_attitude_estimator_unit_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  dcm_est_pkg::req_word_type req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  dcm_est_pkg::rsp_word_type rsp_data,
   input  logic                      csr_we,
   input  logic [2:0]                csr_index,
   input  logic [15:0]               csr_wdata,
   output int                        fail_count,
   output int                        pending_count
);
   import dcm_est_pkg::*;

   localparam int FB = FRAC_BITS;

   logic signed [15:0] bias_x, bias_y, bias_z;
   logic [7:0]         acc_scale;
   logic [15:0]        gyr_gain;
   logic [12:0]        dt;
   logic [14:0]        corr_gain;
   logic [7:0]         ival;
   logic signed [15:0] dcm [9];
   logic signed [15:0] integ [3];
   logic [7:0]         countdown;
   logic [15:0]        angle_rom [ASIN_DEPTH];
   rsp_word_type       attitude_q [$];

   // Sine series and table build, written independently of the package
   function automatic longint unsigned sine_series(longint unsigned x);
      longint unsigned x2, term;
      longint          sum;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 12; k++) begin
         term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      return (sum < 0) ? 0 : longint'(sum);
   endfunction

   task automatic fill_angle_rom();
      longint unsigned top, tgt, lo, hi, mid;
      top = (64'd1686629713 >> (30 - FB)) + 1;
      for (int i = 0; i < ASIN_DEPTH; i++) begin
         tgt = (longint'(i) << 30) / ASIN_DEPTH;
         lo = 0;
         hi = top;
         while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (sine_series((2 * mid + 1) << (29 - FB)) >= tgt) hi = mid;
            else lo = mid + 1;
         end
         angle_rom[i] = lo[15:0];
      end
   endtask

   function automatic logic signed [15:0] qmul(longint a, longint b);
      longint p;
      p = (a * b) >>> FB;
      return p[15:0];
   endfunction

   function automatic logic signed [15:0] lut_asin(logic signed [15:0] x);
      logic [15:0]        mag;
      longint             idx;
      logic signed [15:0] v;
      mag = (x < 0) ? -x : x;
      mag = mag & ((16'd1 << FB) - 1);
      idx = (longint'(mag) * ASIN_DEPTH) >> FB;
      if (idx >= ASIN_DEPTH) idx = ASIN_DEPTH - 1;
      v = angle_rom[idx];
      return (x < 0) ? -v : v;
   endfunction

   function automatic logic signed [15:0] row_weight(logic signed [15:0] d);
      longint t;
      t = ((longint'(3) << FB) - d) >>> 1;
      return t[15:0];
   endfunction

   task automatic reorthonormalize();
      logic signed [15:0] rx [3], ry [3], rz [3];
      logic signed [15:0] er, wx, wy, wz;
      er = 0;
      wx = 0;
      wy = 0;
      wz = 0;
      for (int i = 0; i < 3; i++) er = er + qmul(dcm[i], dcm[3 + i]);
      er = er >>> 1;
      for (int i = 0; i < 3; i++) begin
         rx[i] = dcm[i] - qmul(er, dcm[3 + i]);
         ry[i] = dcm[3 + i] - qmul(er, dcm[i]);
      end
      rz[0] = qmul(rx[1], ry[2]) - qmul(rx[2], ry[1]);
      rz[1] = qmul(rx[2], ry[0]) - qmul(rx[0], ry[2]);
      rz[2] = qmul(rx[0], ry[1]) - qmul(rx[1], ry[0]);
      for (int i = 0; i < 3; i++) begin
         wx = wx + qmul(rx[i], rx[i]);
         wy = wy + qmul(ry[i], ry[i]);
         wz = wz + qmul(rz[i], rz[i]);
      end
      wx = row_weight(wx);
      wy = row_weight(wy);
      wz = row_weight(wz);
      for (int i = 0; i < 3; i++) begin
         dcm[i] = qmul(wx, rx[i]);
         dcm[3 + i] = qmul(wy, ry[i]);
         dcm[6 + i] = qmul(wz, rz[i]);
      end
   endtask

   // Advance the attitude by one sample; queue a word when the countdown expires
   task automatic update_attitude(req_word_type s);
      logic signed [15:0] gy [3], ac [3], err [3], bias [3];
      logic signed [15:0] raw_g [3], raw_a [3];
      logic signed [15:0] dgx, dgy, dgz, r0, r1, r2;
      longint             t;
      rsp_word_type       w;
      bias[0] = bias_x;
      bias[1] = bias_y;
      bias[2] = bias_z;
      raw_g[0] = s.gyro_x;
      raw_g[1] = s.gyro_y;
      raw_g[2] = s.gyro_z;
      raw_a[0] = s.accel_x;
      raw_a[1] = s.accel_y;
      raw_a[2] = s.accel_z;
      for (int i = 0; i < 3; i++) begin
         t = (longint'(raw_g[i]) * longint'(gyr_gain)) >>> FB;
         gy[i] = t[15:0];
         t = (longint'(raw_a[i] >>> 4) - bias[i]) * longint'(acc_scale);
         ac[i] = t[15:0];
      end
      err[0] = qmul(dcm[7], ac[2]) - qmul(dcm[8], ac[1]);
      err[1] = qmul(dcm[8], ac[0]) - qmul(dcm[6], ac[2]);
      err[2] = qmul(dcm[6], ac[1]) - qmul(dcm[7], ac[0]);
      for (int i = 0; i < 3; i++) begin
         integ[i] = integ[i] + (err[i] >>> 8);
         gy[i] = gy[i] - (qmul(corr_gain, err[i]) + integ[i]);
      end
      dgx = qmul(gy[0], dt);
      dgy = qmul(gy[1], dt);
      dgz = qmul(gy[2], dt);
      for (int i = 0; i < 3; i++) begin
         r0 = dcm[3 * i];
         r1 = dcm[3 * i + 1];
         r2 = dcm[3 * i + 2];
         dcm[3 * i] = r0 + qmul(dgz, r1) - qmul(dgy, r2);
         dcm[3 * i + 1] = -qmul(dgz, r0) + r1 + qmul(dgx, r2);
         dcm[3 * i + 2] = qmul(dgy, r0) - qmul(dgx, r1) + r2;
      end
      reorthonormalize();
      countdown = countdown - 8'd1;
      if (countdown == 0) begin
         w.pitch = lut_asin(dcm[6]);
         w.roll = lut_asin(dcm[7]);
         attitude_q.push_back(w);
         countdown = (ival == 0) ? 8'd1 : ival;
      end
   endtask

   initial begin
      fill_angle_rom();
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         fail_count = 0;
         bias_x = 11;
         bias_y = 1;
         bias_z = 4;
         acc_scale = 8;
         gyr_gain = 10580;
         dt = 82;
         corr_gain = 9011;
         ival = 10;
         for (int i = 0; i < 9; i++) dcm[i] = (i % 4 == 0) ? 16'sd8192 : 16'sd0;
         for (int i = 0; i < 3; i++) integ[i] = 0;
         countdown = 10;
         attitude_q.delete();
      end else begin
         // Register writes
         if (csr_we) begin
            case (csr_index)
               CSR_BIAS_X: bias_x = {{4{csr_wdata[11]}}, csr_wdata[11:0]};
               CSR_BIAS_Y: bias_y = {{4{csr_wdata[11]}}, csr_wdata[11:0]};
               CSR_BIAS_Z: bias_z = {{4{csr_wdata[11]}}, csr_wdata[11:0]};
               CSR_SCALE:  acc_scale = csr_wdata[7:0];
               CSR_GAIN:   gyr_gain = csr_wdata;
               CSR_DT:     dt = csr_wdata[12:0];
               CSR_CG:     corr_gain = csr_wdata[14:0];
               CSR_IVAL:   ival = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) update_attitude(req_data);
         // Compare the result word with the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (attitude_q.size() == 0) begin
               $error("unexpected result word pitch=%0d roll=%0d",
                      rsp_data.pitch, rsp_data.roll);
               fail_count++;
            end else begin
               want = attitude_q.pop_front();
               if (rsp_data.pitch !== want.pitch) begin
                  $error("pitch: expected %0d, got %0d", want.pitch, rsp_data.pitch);
                  fail_count++;
               end
               if (rsp_data.roll !== want.roll) begin
                  $error("roll: expected %0d, got %0d", want.roll, rsp_data.roll);
                  fail_count++;
               end
            end
         end
      end
      pending_count = attitude_q.size();
   end
endmodule

/* tb/dcm_attitude_estimator_unit_tb.sv */
`timescale 1ns / 1ps

module dcm_attitude_estimator_unit_tb;
   import dcm_est_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_data;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_index = CSR_BIAS_X;
   logic [15:0]  csr_wdata = '0;
   int           fail_count;
   int           pending_count;
   bit           calm_phase = 1'b0;
   bit           hold_rsp = 1'b0;

   dcm_attitude_estimator_unit u_top (.*);

   dcm_attitude_estimator_unit_checker u_chk (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random stall bursts, or a long hold when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_rsp) begin
         rsp_ready <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 10) - 1) @(posedge clock);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'($signed($urandom_range(0, 4000)) - 2000);
         default: return 16'($urandom());
      endcase
   endfunction

   // Offer one sample word, hold it until accepted, then idle with valid low
   task automatic send_sample(req_word_type s);
      if (!calm_phase && $urandom_range(0, 5) == 0)
         repeat ($urandom_range(0, 9)) @(posedge clock);
      req_valid <= 1'b1;
      req_data <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random(int n);
      req_word_type s;
      for (int k = 0; k < n; k++) begin
         s.gyro_x = pick16();
         s.gyro_y = pick16();
         s.gyro_z = pick16();
         s.accel_x = pick16();
         s.accel_y = pick16();
         s.accel_z = pick16();
         send_sample(s);
      end
   endtask

   task automatic wait_drain();
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all(logic [15:0] bx, logic [15:0] by, logic [15:0] bz,
                            logic [15:0] sc, logic [15:0] gg, logic [15:0] ts,
                            logic [15:0] cg, logic [15:0] iv);
      write_reg(CSR_BIAS_X, bx);
      write_reg(CSR_BIAS_Y, by);
      write_reg(CSR_BIAS_Z, bz);
      write_reg(CSR_SCALE, sc);
      write_reg(CSR_GAIN, gg);
      write_reg(CSR_DT, ts);
      write_reg(CSR_CG, cg);
      write_reg(CSR_IVAL, iv);
   endtask

   initial begin
      req_word_type s;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes at default settings
      s = '{16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
      send_sample(s);
      s = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000};
      send_sample(s);
      s = '0;
      for (int k = 0; k < 8; k++) send_sample(s);
      wait_drain();

      // Interval zero acts as one, with extreme registers
      write_all(16'h0800, 16'h07FF, 16'h0000, 16'h00FF, 16'hFFFF, 16'h1FFF, 16'h7FFF, 16'h0);
      send_random(4);
      wait_drain();
      // Countdown reload picks up the new interval
      write_reg(CSR_IVAL, 16'd1);
      send_random(6);
      wait_drain();
      write_all(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'd255);
      send_random(5);
      wait_drain();

      // Random phases with several settings
      for (int ph = 0; ph < 6; ph++) begin
         write_all(16'($urandom()), 16'($urandom()), 16'($urandom()),
                   16'($urandom_range(0, 255)), 16'($urandom()),
                   16'($urandom_range(0, 8191)), 16'($urandom_range(0, 32767)),
                   16'($urandom_range(1, 4)));
         if (ph == 2) begin
            // Long receiver hold while samples keep coming
            hold_rsp <= 1'b1;
            fork
               send_random(8);
               begin
                  repeat (2000) @(posedge clock);
                  hold_rsp <= 1'b0;
               end
            join
         end
         send_random(140);
         wait_drain();
      end

      // Calm tail at reset-like defaults
      calm_phase = 1'b1;
      write_all(16'd11, 16'd1, 16'd4, 16'd8, 16'd10580, 16'd82, 16'd9011, 16'd1);
      send_random(100);
      wait_drain();

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end
endmodule
